// ===== hdl/dsc_pkg.sv =====
// shared types and constants for the distinct subsequence counter
// no dependencies; imported by every module of the block
package dsc_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int CHAR_W      = 8;
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W       = 5;
    localparam int MATCH_W     = 32;
    localparam int CMD_W       = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_TEXT    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    // per-cell control for one accepted item
    typedef struct packed {
        logic text_step;   // text byte, cell in use
        logic restart;     // clear the count
        logic load;        // pattern byte targets this cell
    } cell_ctrl_t;

endpackage

// ===== hdl/dsc_cell.sv =====
// one pattern position: stored pattern byte and saturating prefix count
// depends on dsc_pkg
module dsc_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  dsc_pkg::cell_ctrl_t         ctrl,
    input  logic [dsc_pkg::CHAR_W-1:0]  char_value,
    input  logic [dsc_pkg::COUNT_WIDTH-1:0] prev_count,
    output logic [dsc_pkg::COUNT_WIDTH-1:0] count,
    output logic                        sat_hit
);
    import dsc_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [CHAR_W-1:0]      pchar_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] sat_sum;
    logic                   match;

    // saturating add of the neighbor's old count
    assign sum     = {1'b0, count_reg} + {1'b0, prev_count};
    assign sat_sum = sum[COUNT_WIDTH] ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
    assign match   = ctrl.text_step && (pchar_reg == char_value);

    always_comb begin
        count_next = count_reg;
        if (ctrl.restart) begin
            count_next = '0;
        end else if (match) begin
            count_next = sat_sum;
        end
    end

    assign sat_hit = match && (sat_sum == COUNT_MAX);
    assign count   = count_reg;

    // pattern byte, no reset
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            pchar_reg <= char_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== hdl/dsc_chain.sv =====
// row of pattern cells fed by the lower neighbor's count; cell 0 gets 1
// depends on dsc_pkg and dsc_cell
module dsc_chain (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  dsc_pkg::cmd_t                    cmd,
    input  logic                             step_en,
    input  logic [dsc_pkg::CHAR_W-1:0]       char_value,
    input  logic [dsc_pkg::IDX_W-1:0]        pattern_index,
    input  logic [dsc_pkg::LEN_W-1:0]        pattern_length,
    output logic [dsc_pkg::COUNT_WIDTH-1:0]  report_count,
    output logic                             any_sat
);
    import dsc_pkg::*;

    localparam int SEL_W = LEN_W + 1;

    logic [COUNT_WIDTH-1:0] counts [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] hits;
    logic                   do_load;
    logic                   do_text;
    logic                   do_restart;
    logic [IDX_W-1:0]       sel;

    // command decode
    always_comb begin
        do_load    = 1'b0;
        do_text    = 1'b0;
        do_restart = 1'b0;
        unique case (cmd)
            CMD_LOAD:    do_load    = step_en;
            CMD_TEXT:    do_text    = step_en;
            CMD_RESTART: do_restart = step_en;
            default:     ;
        endcase
    end

    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        cell_ctrl_t             ctrl;
        logic [COUNT_WIDTH-1:0] prev;

        assign ctrl.text_step = do_text && (SEL_W'(j) < SEL_W'(pattern_length));
        assign ctrl.restart   = do_restart;
        assign ctrl.load      = do_load && (pattern_index == IDX_W'(j));

        if (j == 0) begin : g_first
            assign prev = COUNT_WIDTH'(1);
        end else begin : g_rest
            assign prev = counts[j-1];
        end

        dsc_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .char_value (char_value),
            .prev_count (prev),
            .count      (counts[j]),
            .sat_hit    (hits[j])
        );
    end

    assign any_sat = |hits;

    // count of the whole pattern; length zero reports one, lengths past the row use the last cell
    always_comb begin
        if (SEL_W'(pattern_length) >= SEL_W'(MAX_PATTERN)) begin
            sel = IDX_W'(MAX_PATTERN - 1);
        end else begin
            sel = IDX_W'(pattern_length - LEN_W'(1));
        end
        if (pattern_length == '0) begin
            report_count = COUNT_WIDTH'(1);
        end else begin
            report_count = counts[sel];
        end
    end

endmodule

// ===== hdl/distinct_subsequence_counter_core.sv =====
// top level of the distinct subsequence counter: handshakes, config, result
// depends on dsc_pkg and dsc_chain
//
// Usage:
//   s_ channel carries one command item (load pattern byte, text byte,
//   restart, or no-op); every accepted item yields exactly one m_ item with
//   the count of distinct subsequences of the text so far equal to the whole
//   pattern, plus a sticky saturated flag.
//   cfg channel writes pattern_length (always ready); write only while idle.
//   Result path: the cell row updates at the accepting edge, and the report
//   is read from the cells into the output register once that register is
//   free to take it.
//   Throughput: one item per cycle while m_ready stays high; every cell does
//   its saturating add in parallel in the same cycle, so the chain never holds the flow.
//   Reset (aresetn low, synchronous) clears counts, flag, length and valids;
//   pattern bytes are undefined until loaded.
//   When m_ready stays low, one further item is still taken into the
//   pending stage, then s_ready drops until the output register drains.
module distinct_subsequence_counter_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [dsc_pkg::CMD_W-1:0]        s_command,
    input  logic [dsc_pkg::CHAR_W-1:0]       s_char_value,
    input  logic [dsc_pkg::IDX_W-1:0]        s_pattern_index,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [dsc_pkg::MATCH_W-1:0]      m_match_count,
    output logic                             m_saturated,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dsc_pkg::LEN_W-1:0]        cfg_data
);
    import dsc_pkg::*;

    logic                   accept;
    logic                   out_free;
    logic                   pend_reg;
    logic                   pend_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [MATCH_W-1:0]     count_out_reg;
    logic                   sat_out_reg;
    logic                   flag_reg;
    logic                   flag_next;
    logic [LEN_W-1:0]       len_reg;
    logic [COUNT_WIDTH-1:0] report_count;
    logic                   any_sat;
    cmd_t                   cmd;

    assign cmd      = cmd_t'(s_command);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !pend_reg || out_free;
    assign accept   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    dsc_chain u_chain (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .step_en        (accept),
        .char_value     (s_char_value),
        .pattern_index  (s_pattern_index),
        .pattern_length (len_reg),
        .report_count   (report_count),
        .any_sat        (any_sat)
    );

    // sticky saturation flag, cleared by restart
    always_comb begin
        flag_next = flag_reg;
        if (accept && (cmd == CMD_RESTART)) begin
            flag_next = 1'b0;
        end else if (any_sat) begin
            flag_next = 1'b1;
        end
    end

    // pending stage and output register control
    always_comb begin
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = pend_reg;
            pend_next    = accept;
        end else if (accept) begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            flag_reg    <= 1'b0;
            len_reg     <= '0;
        end else begin
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            flag_reg    <= flag_next;
            if (cfg_valid) begin
                len_reg <= cfg_data;
            end
        end
    end

    // result payload, loaded when the pending report moves out
    always_ff @(posedge aclk) begin
        if (out_free && pend_reg) begin
            count_out_reg <= MATCH_W'(report_count);
            sat_out_reg   <= flag_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_match_count = count_out_reg;
    assign m_saturated   = sat_out_reg;

endmodule

// ===== bench/distinct_subsequence_counter_core_tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for distinct_subsequence_counter_core: a directed table, then random phases
// checked against a cycle-free count model; depends on dsc_pkg and the core rtl
module distinct_subsequence_counter_core_tb;
    import dsc_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam int RANDOM_ITEMS = 1000;

    typedef struct packed {
        logic [MATCH_W-1:0] count;
        logic               sat;
    } report_t;

    // one row of the directed table: either a length write or an item
    typedef struct packed {
        logic               cfg_row;
        logic [LEN_W-1:0]   len;
        cmd_t               cmd;
        logic [CHAR_W-1:0]  ch;
        logic [IDX_W-1:0]   idx;
        logic               typed;
        logic [MATCH_W-1:0] count;
        logic               sat;
    } dir_row_t;

    localparam int DIR_ROWS  = 24;
    localparam int DIR_IDX_W = $clog2(DIR_ROWS);

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [CMD_W-1:0]    s_command;
    logic [CHAR_W-1:0]   s_char_value;
    logic [IDX_W-1:0]    s_pattern_index;
    logic                m_valid;
    logic                m_ready;
    logic [MATCH_W-1:0]  m_match_count;
    logic                m_saturated;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [LEN_W-1:0]    cfg_data;

    // predictor state
    logic [CHAR_W-1:0]      pat_chars [MAX_PATTERN];
    logic [COUNT_WIDTH-1:0] prefix_cnt [MAX_PATTERN];
    logic                   overflow_flag;
    logic [LEN_W-1:0]       pat_len;

    report_t reports_due [$];
    int      fail_count;
    bit      send_burst;
    bit      recv_burst;
    logic [CHAR_W-1:0] alpha_base;
    int      alpha_size;

    dir_row_t dir_tbl [DIR_ROWS] = '{
        // empty pattern after reset reports one
        '{1'b1, 5'd0,  CMD_NOP,     8'h00, 4'd0,  1'b0, 32'd0, 1'b0},
        '{1'b0, 5'd0,  CMD_NOP,     8'h00, 4'd0,  1'b1, 32'd1, 1'b0},
        '{1'b0, 5'd0,  CMD_TEXT,    8'hFF, 4'd0,  1'b1, 32'd1, 1'b0},
        '{1'b0, 5'd0,  CMD_RESTART, 8'h00, 4'd0,  1'b1, 32'd1, 1'b0},
        // two-byte pattern with the char extremes
        '{1'b1, 5'd2,  CMD_NOP,     8'h00, 4'd0,  1'b0, 32'd0, 1'b0},
        '{1'b0, 5'd0,  CMD_LOAD,    8'h00, 4'd0,  1'b1, 32'd0, 1'b0},
        '{1'b0, 5'd0,  CMD_LOAD,    8'hFF, 4'd1,  1'b1, 32'd0, 1'b0},
        '{1'b0, 5'd0,  CMD_TEXT,    8'h00, 4'd0,  1'b1, 32'd0, 1'b0},
        '{1'b0, 5'd0,  CMD_TEXT,    8'hFF, 4'd0,  1'b0, 32'd0, 1'b0},
        '{1'b0, 5'd0,  CMD_TEXT,    8'h00, 4'd0,  1'b0, 32'd0, 1'b0},
        '{1'b0, 5'd0,  CMD_TEXT,    8'hFF, 4'd0,  1'b0, 32'd0, 1'b0},
        '{1'b0, 5'd0,  CMD_NOP,     8'h00, 4'd0,  1'b0, 32'd0, 1'b0},
        // length shrunk and grown again with no restart: stale counts stay
        '{1'b1, 5'd1,  CMD_NOP,     8'h00, 4'd0,  1'b0, 32'd0, 1'b0},
        '{1'b0, 5'd0,  CMD_TEXT,    8'h00, 4'd0,  1'b0, 32'd0, 1'b0},
        '{1'b0, 5'd0,  CMD_TEXT,    8'hFF, 4'd0,  1'b0, 32'd0, 1'b0},
        '{1'b1, 5'd2,  CMD_NOP,     8'h00, 4'd0,  1'b0, 32'd0, 1'b0},
        '{1'b0, 5'd0,  CMD_TEXT,    8'hFF, 4'd0,  1'b0, 32'd0, 1'b0},
        '{1'b0, 5'd0,  CMD_RESTART, 8'h00, 4'd0,  1'b1, 32'd0, 1'b0},
        // top pattern slot, then full and over-range lengths
        '{1'b0, 5'd0,  CMD_LOAD,    8'hAA, 4'd15, 1'b1, 32'd0, 1'b0},
        '{1'b0, 5'd0,  CMD_LOAD,    8'h55, 4'd15, 1'b1, 32'd0, 1'b0},
        '{1'b1, 5'd16, CMD_NOP,     8'h00, 4'd0,  1'b0, 32'd0, 1'b0},
        '{1'b0, 5'd0,  CMD_NOP,     8'h00, 4'd0,  1'b1, 32'd0, 1'b0},
        '{1'b1, 5'd31, CMD_NOP,     8'h00, 4'd0,  1'b0, 32'd0, 1'b0},
        '{1'b0, 5'd0,  CMD_NOP,     8'h00, 4'd0,  1'b1, 32'd0, 1'b0}
    };

    distinct_subsequence_counter_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_char_value    (s_char_value),
        .s_pattern_index (s_pattern_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_match_count   (m_match_count),
        .m_saturated     (m_saturated),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // count model: one accepted item in, one report out
    task automatic count_step(input cmd_t cmd, input logic [CHAR_W-1:0] ch,
                              input logic [IDX_W-1:0] idx, output report_t rep);
        int                     eff;
        int                     j;
        logic [COUNT_WIDTH:0]   sum;
        logic [COUNT_WIDTH-1:0] prev;
        eff = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
        case (cmd)
            CMD_LOAD: begin
                pat_chars[idx] = ch;
            end
            CMD_TEXT: begin
                // high to low so each cell adds the old count below it
                for (j = eff - 1; j >= 0; j--) begin
                    if (pat_chars[IDX_W'(j)] == ch) begin
                        if (j == 0) prev = COUNT_WIDTH'(1);
                        else prev = prefix_cnt[IDX_W'(j-1)];
                        sum = {1'b0, prefix_cnt[IDX_W'(j)]} + {1'b0, prev};
                        if (sum > {1'b0, COUNT_MAX}) sum = {1'b0, COUNT_MAX};
                        prefix_cnt[IDX_W'(j)] = sum[COUNT_WIDTH-1:0];
                        if (prefix_cnt[IDX_W'(j)] == COUNT_MAX) overflow_flag = 1'b1;
                    end
                end
            end
            CMD_RESTART: begin
                for (j = 0; j < MAX_PATTERN; j++) prefix_cnt[IDX_W'(j)] = '0;
                overflow_flag = 1'b0;
            end
            default: begin
            end
        endcase
        if (eff == 0) rep.count = MATCH_W'(1);
        else rep.count = MATCH_W'(prefix_cnt[IDX_W'(eff-1)]);
        rep.sat = overflow_flag;
    endtask

    // drive one item after a random gap and hold it until taken
    task automatic send_item(input cmd_t cmd, input logic [CHAR_W-1:0] ch,
                             input logic [IDX_W-1:0] idx,
                             input bit typed = 1'b0, input report_t typed_rep = '0);
        int      gap;
        report_t rep;
        gap = send_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_char_value    <= ch;
        s_pattern_index <= idx;
        do @(posedge aclk); while (s_ready !== 1'b1);
        count_step(cmd, ch, idx, rep);
        reports_due.push_back(typed ? typed_rep : rep);
    endtask

    // drop valid and wait for every pending report
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        pat_len = len;
    endtask

    // a byte from the small alphabet of the current phase
    function automatic logic [CHAR_W-1:0] pick_char();
        return alpha_base ^ CHAR_W'($urandom_range(0, alpha_size - 1));
    endfunction

    // result side: random stall per item, check against the oldest report
    initial begin
        report_t want;
        int      w;
        m_ready = 1'b0;
        forever begin
            w = recv_burst ? 0 : $urandom_range(0, 19);
            if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (reports_due.size() == 0) begin
                $error("unexpected item: match_count %0d saturated %0b",
                       m_match_count, m_saturated);
                fail_count++;
            end else begin
                want = reports_due.pop_front();
                if (m_match_count !== want.count) begin
                    $error("match_count: expected %0d, actual %0d", want.count, m_match_count);
                    fail_count++;
                end
                if (m_saturated !== want.sat) begin
                    $error("saturated: expected %0b, actual %0b", want.sat, m_saturated);
                    fail_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        int               r;
        int               p;
        int               k;
        int               n;
        int               eff;
        int               pick;
        int               phase;
        int               rand_items;
        bit               sat_phase;
        logic [LEN_W-1:0] new_len;
        report_t          typed_rep;

        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_command       = CMD_NOP;
        s_char_value    = '0;
        s_pattern_index = '0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        fail_count      = 0;
        send_burst      = 1'b0;
        recv_burst      = 1'b0;
        alpha_base      = '0;
        alpha_size      = 1;
        for (p = 0; p < MAX_PATTERN; p++) begin
            pat_chars[IDX_W'(p)]  = '0;
            prefix_cnt[IDX_W'(p)] = '0;
        end
        overflow_flag = 1'b0;
        pat_len       = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (r = 0; r < DIR_ROWS; r++) begin
            if (dir_tbl[DIR_IDX_W'(r)].cfg_row) begin
                wait_drained();
                write_length(dir_tbl[DIR_IDX_W'(r)].len);
            end else begin
                typed_rep.count = dir_tbl[DIR_IDX_W'(r)].count;
                typed_rep.sat   = dir_tbl[DIR_IDX_W'(r)].sat;
                send_item(dir_tbl[DIR_IDX_W'(r)].cmd, dir_tbl[DIR_IDX_W'(r)].ch,
                          dir_tbl[DIR_IDX_W'(r)].idx, dir_tbl[DIR_IDX_W'(r)].typed,
                          typed_rep);
            end
        end

        // random phases: length, restart, full pattern load, then a text stream
        phase      = 0;
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            sat_phase  = (phase == 0) || ($urandom_range(0, 11) == 0);
            alpha_base = CHAR_W'($urandom_range(0, 255));
            alpha_size = $urandom_range(1, 4);
            pick       = $urandom_range(0, 19);
            if (sat_phase) new_len = LEN_W'(MAX_PATTERN);
            else if (pick < 2) new_len = '0;
            else if (pick < 4) new_len = LEN_W'(MAX_PATTERN);
            else if (pick == 4) new_len = LEN_W'($urandom_range(MAX_PATTERN + 1, 31));
            else new_len = LEN_W'($urandom_range(1, MAX_PATTERN - 1));
            eff = (new_len > MAX_PATTERN) ? MAX_PATTERN : int'(new_len);

            wait_drained();
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
            write_length(new_len);

            send_item(CMD_RESTART, CHAR_W'($urandom), IDX_W'($urandom));
            // one repeated byte saturates the deep prefixes within a few dozen items
            for (p = 0; p < eff; p++)
                send_item(CMD_LOAD, sat_phase ? alpha_base : pick_char(), IDX_W'(p));

            n = sat_phase ? 40 + $urandom_range(0, 8) : $urandom_range(5, 40);
            for (k = 0; k < n; k++) begin
                if (sat_phase) begin
                    send_item(CMD_TEXT, alpha_base, IDX_W'($urandom));
                end else if ($urandom_range(0, 99) < 82) begin
                    send_item(CMD_TEXT, pick_char(), IDX_W'($urandom));
                end else begin
                    // noise: idle command, restart, pattern rewrite, stray byte
                    case ($urandom_range(0, 3))
                        0: send_item(CMD_NOP, CHAR_W'($urandom), IDX_W'($urandom));
                        1: send_item(CMD_RESTART, CHAR_W'($urandom), IDX_W'($urandom));
                        2: send_item(CMD_LOAD, pick_char(), IDX_W'($urandom));
                        default: send_item(CMD_TEXT, CHAR_W'($urandom), IDX_W'($urandom));
                    endcase
                end
            end
            rand_items += 1 + eff + n;
            phase++;
        end

        // drain and let the pipeline settle
        wait_drained();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
